@@ hw/rtl/fths_pkg.sv @@
// Shared types, codes and float helpers for the tensor health statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none

package fths_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CLASS_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // activation kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_SIGMOID = 3'd1;
    localparam logic [2:0] KIND_TANH    = 3'd2;
    localparam logic [2:0] KIND_RELU    = 3'd3;
    localparam logic [2:0] KIND_SOFTMAX = 3'd4;

    // register indexes
    localparam logic [1:0] CFG_PRODUCER_KIND       = 2'd0;
    localparam logic [1:0] CFG_EXPLODING_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_SOFTMAX_THRESHOLD   = 2'd2;
    localparam logic [1:0] CFG_ROW_LENGTH          = 2'd3;

    localparam logic [31:0] F32_POS_INF = 32'h7F80_0000;
    localparam logic [31:0] F32_NEG_INF = 32'hFF80_0000;
    // largest float32 not above 0.01, smallest float32 not below 0.99
    localparam logic [30:0] F32_LOW_EDGE  = 31'h3C23_D70A;
    localparam logic [30:0] F32_HIGH_EDGE = 31'h3F7D_70A4;

    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] bits;
        logic        finite;
        logic        nan;
        logic        inf;
        logic        zero;
        logic        exploding;
        logic        cand;
        logic [63:0] v64;
        logic [63:0] sq64;
    } elem_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [29:0]            softmax_threshold;
        logic [CLASS_WIDTH-1:0] row_length;
    } acc_cfg_t;

    typedef struct packed {
        count_t      finite_total;
        count_t      nan_total;
        count_t      inf_total;
        count_t      zero_total;
        count_t      exploding_total;
        count_t      saturated_total;
        count_t      observed_total;
        logic        saturation_valid;
        logic [31:0] min_bits;
        logic [31:0] max_bits;
        logic [63:0] sum_bits;
        logic [63:0] sum_squares_bits;
    } result_t;

    function automatic count_t sat_inc(input count_t c, input logic hit);
        sat_inc = (hit && (c != '1)) ? c + count_t'(1) : c;
    endfunction

    // a < b for non-NaN float32, with -0 == +0
    function automatic logic f32_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : {1'b1, a[30:0]};
        kb = b[31] ? ~b : {1'b1, b[30:0]};
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
            f32_lt = 1'b0;
        else
            f32_lt = ka < kb;
    endfunction

    function automatic logic [4:0] msb23(input logic [22:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 23; i++)
            if (v[i])
                p = 5'(i);
        msb23 = p;
    endfunction

    function automatic logic [5:0] lzc56(input logic [55:0] v);
        logic [5:0] n;
        logic       found;
        n = 6'd0;
        found = 1'b0;
        for (int i = 55; i >= 0; i--)
            if (!found)
            begin
                if (v[i])
                    found = 1'b1;
                else
                    n = n + 6'd1;
            end
        lzc56 = n;
    endfunction

    // float64 add, round to nearest even; operands are normal or zero
    function automatic logic [63:0] f64_add(input logic [63:0] x, input logic [63:0] y);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [10:0]  ea;
        logic [10:0]  d;
        logic [10:0]  e;
        logic [113:0] wide;
        logic [55:0]  am;
        logic [55:0]  bm;
        logic [55:0]  m;
        logic [56:0]  s;
        logic [5:0]   lz;
        logic [53:0]  rm;
        logic         up;
        logic [63:0]  res;
        if (x[62:0] >= y[62:0])
        begin
            a = x;
            b = y;
        end
        else
        begin
            a = y;
            b = x;
        end
        ea = a[62:52];
        d = a[62:52] - b[62:52];
        am = {1'b1, a[51:0], 3'b000};
        wide = {1'b1, b[51:0], 61'd0} >> d;
        if (d > 11'd57)
            bm = 56'd1;
        else
            bm = wide[113:58] | {55'd0, |wide[57:0]};
        m = 56'd0;
        e = ea;
        res = 64'd0;
        if (a[63] == b[63])
        begin
            s = {1'b0, am} + {1'b0, bm};
            if (s[56])
            begin
                m = {s[56:2], s[1] | s[0]};
                e = ea + 11'd1;
            end
            else
                m = s[55:0];
        end
        else
        begin
            s = {1'b0, am - bm};
            lz = lzc56(s[55:0]);
            m = s[55:0] << lz;
            e = ea - {5'd0, lz};
        end
        up = m[2] & (m[1] | m[0] | m[3]);
        rm = {1'b0, m[55:3]} + {53'd0, up};
        if (rm[53])
            res = {a[63], e + 11'd1, 52'd0};
        else
            res = {a[63], e, rm[51:0]};
        if ((x[62:0] == 63'd0) && (y[62:0] == 63'd0))
            f64_add = {x[63] & y[63], 63'd0};
        else if (y[62:0] == 63'd0)
            f64_add = x;
        else if (x[62:0] == 63'd0)
            f64_add = y;
        else if ((a[63] != b[63]) && (m == 56'd0))
            f64_add = 64'd0;
        else
            f64_add = res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fths_front.sv @@
// Input register and element classification: class flags, saturation candidate,
// float64 value and its exact square. Depends on fths_pkg.
`default_nettype none

module fths_front
    import fths_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] value_bits,
    input  wire logic        last_element,
    input  wire logic [2:0]  kind,
    input  wire logic [30:0] exploding_threshold,
    output elem_t            elem
);

    logic        in_valid_reg;
    logic [31:0] bits_reg;
    logic        last_reg;
    logic        mid_valid_reg;
    elem_t       mid_reg;
    elem_t       mid_next;

    logic [30:0] mag;
    logic [4:0]  p;
    logic [23:0] nsig;
    logic [10:0] e64;
    logic [47:0] prod;
    logic [11:0] sq_exp;

    always_comb
    begin
        mag = bits_reg[30:0];
        p = msb23(bits_reg[22:0]);
        if (bits_reg[30:23] != 8'd0)
        begin
            nsig = {1'b1, bits_reg[22:0]};
            e64 = {3'd0, bits_reg[30:23]} + 11'd896;
        end
        else
        begin
            nsig = {1'b0, bits_reg[22:0]} << (5'd23 - p);
            e64 = {6'd0, p} + 11'd874;
        end
        prod = nsig * nsig;
        sq_exp = {e64, 1'b0} - 12'd1023 + {11'd0, prod[47]};

        mid_next.valid = in_valid_reg;
        mid_next.last = last_reg;
        mid_next.bits = bits_reg;
        mid_next.nan = mag > F32_POS_INF[30:0];
        mid_next.inf = mag == F32_POS_INF[30:0];
        mid_next.finite = !mid_next.nan && !mid_next.inf;
        mid_next.zero = mag == 31'd0;
        mid_next.exploding = mid_next.finite && (mag >= exploding_threshold);
        unique case (kind)
            KIND_SIGMOID: mid_next.cand = bits_reg[31] || (mag <= F32_LOW_EDGE)
                                          || (mag >= F32_HIGH_EDGE);
            KIND_TANH:    mid_next.cand = mag >= F32_HIGH_EDGE;
            KIND_RELU:    mid_next.cand = bits_reg[31] || mid_next.zero;
            default:      mid_next.cand = 1'b0;
        endcase
        if (mid_next.zero)
        begin
            mid_next.v64 = {bits_reg[31], 63'd0};
            mid_next.sq64 = 64'd0;
        end
        else
        begin
            mid_next.v64 = {bits_reg[31], e64, nsig[22:0], 29'd0};
            mid_next.sq64 = prod[47] ? {1'b0, sq_exp[10:0], prod[46:0], 5'd0}
                                     : {1'b0, sq_exp[10:0], prod[45:0], 6'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mid_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= in_valid;
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (in_valid)
            begin
                bits_reg <= value_bits;
                last_reg <= last_element;
            end
            mid_reg <= mid_next;
        end
    end

    always_comb
    begin
        elem = mid_reg;
        elem.valid = mid_valid_reg;
    end

endmodule

`default_nettype wire

@@ hw/rtl/fths_accum.sv @@
// Running tensor state (counters, min/max, softmax rows, float64 sums) and the
// summary result register. Depends on fths_pkg.
`default_nettype none

module fths_accum
    import fths_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  elem_t         elem,
    input  acc_cfg_t      cfg,
    output logic          en,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       result
);

    count_t                 finite_reg, nan_reg, inf_reg, zero_reg;
    count_t                 expl_reg, sat_reg, row_reg;
    logic [CLASS_WIDTH-1:0] col_reg;
    logic [31:0]            rowmax_reg, min_reg, max_reg;
    logic [63:0]            sum_reg, sq_reg;

    count_t                 finite_next, nan_next, inf_next, zero_next;
    count_t                 expl_next, sat_next, row_next;
    logic [CLASS_WIDTH-1:0] col_next, col_inc;
    logic [31:0]            rowmax_next, rowmax_upd, min_next, max_next;
    logic [63:0]            sum_next, sq_next;
    logic                   row_done, soft_hit, upd, load;

    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                result_next;

    assign en = !(elem.valid && elem.last && out_valid_reg && !out_ready);
    assign upd = en && elem.valid;
    assign load = upd && elem.last;

    always_comb
    begin
        finite_next = sat_inc(finite_reg, elem.finite);
        nan_next = sat_inc(nan_reg, elem.nan);
        inf_next = sat_inc(inf_reg, elem.inf);
        zero_next = sat_inc(zero_reg, elem.finite && elem.zero);
        expl_next = sat_inc(expl_reg, elem.exploding);
        min_next = (elem.finite && f32_lt(elem.bits, min_reg)) ? elem.bits : min_reg;
        max_next = (elem.finite && f32_lt(max_reg, elem.bits)) ? elem.bits : max_reg;
        rowmax_upd = (elem.finite && f32_lt(rowmax_reg, elem.bits)) ? elem.bits
                                                                     : rowmax_reg;
        sum_next = elem.finite ? f64_add(sum_reg, elem.v64) : sum_reg;
        sq_next = elem.finite ? f64_add(sq_reg, elem.sq64) : sq_reg;

        // softmax row bookkeeping; every element advances the column unless the row length is zero
        col_inc = col_reg + CLASS_WIDTH'(1);
        row_done = (cfg.row_length != '0) && (col_inc >= cfg.row_length);
        if (cfg.row_length == '0)
            col_next = col_reg;
        else if (row_done)
            col_next = '0;
        else
            col_next = col_inc;
        row_next = sat_inc(row_reg, row_done);
        soft_hit = row_done && (cfg.kind == KIND_SOFTMAX)
                   && !f32_lt(rowmax_upd, {2'b00, cfg.softmax_threshold});
        sat_next = sat_inc(sat_reg, (elem.finite && elem.cand) || soft_hit);
        rowmax_next = row_done ? F32_NEG_INF : rowmax_upd;

        result_next.finite_total = finite_next;
        result_next.nan_total = nan_next;
        result_next.inf_total = inf_next;
        result_next.zero_total = zero_next;
        result_next.exploding_total = expl_next;
        result_next.saturation_valid = 1'b0;
        result_next.saturated_total = '0;
        result_next.observed_total = '0;
        if ((cfg.kind == KIND_SIGMOID) || (cfg.kind == KIND_TANH)
            || (cfg.kind == KIND_RELU))
        begin
            result_next.saturation_valid = 1'b1;
            result_next.saturated_total = sat_next;
            result_next.observed_total = finite_next;
        end
        else if ((cfg.kind == KIND_SOFTMAX) && (cfg.row_length != '0)
                 && (col_next == '0))
        begin
            result_next.saturation_valid = 1'b1;
            result_next.saturated_total = sat_next;
            result_next.observed_total = row_next;
        end
        result_next.min_bits = (finite_next != '0) ? min_next : 32'd0;
        result_next.max_bits = (finite_next != '0) ? max_next : 32'd0;
        result_next.sum_bits = sum_next;
        result_next.sum_squares_bits = sq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finite_reg <= '0;
            nan_reg <= '0;
            inf_reg <= '0;
            zero_reg <= '0;
            expl_reg <= '0;
            sat_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            rowmax_reg <= F32_NEG_INF;
            min_reg <= F32_POS_INF;
            max_reg <= F32_NEG_INF;
            sum_reg <= 64'd0;
            sq_reg <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                // tensor done: back to reset values
                finite_reg <= '0;
                nan_reg <= '0;
                inf_reg <= '0;
                zero_reg <= '0;
                expl_reg <= '0;
                sat_reg <= '0;
                row_reg <= '0;
                col_reg <= '0;
                rowmax_reg <= F32_NEG_INF;
                min_reg <= F32_POS_INF;
                max_reg <= F32_NEG_INF;
                sum_reg <= 64'd0;
                sq_reg <= 64'd0;
            end
            else if (upd)
            begin
                finite_reg <= finite_next;
                nan_reg <= nan_next;
                inf_reg <= inf_next;
                zero_reg <= zero_next;
                expl_reg <= expl_next;
                sat_reg <= sat_next;
                row_reg <= row_next;
                col_reg <= col_next;
                rowmax_reg <= rowmax_next;
                min_reg <= min_next;
                max_reg <= max_next;
                sum_reg <= sum_next;
                sq_reg <= sq_next;
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result = result_reg;

    a_one_class: assert property (@(posedge clk) disable iff (!rst_n)
        elem.valid |-> $onehot({elem.nan, elem.inf, elem.finite}))
        else $error("element falls in more or less than one class");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (finite_reg == '0) && (col_reg == '0) && (sum_reg == 64'd0))
        else $error("state not cleared after summary beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || out_ready))
        else $error("summary overwrote an untaken result");

    a_sum_not_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg != 64'h8000_0000_0000_0000)
        else $error("running sum became negative zero");

endmodule

`default_nettype wire

@@ hw/rtl/float_tensor_health_statistics.sv @@
// Top level of the tensor health statistics block: configuration registers and
// the front and accumulate pipeline stages. Depends on fths_pkg, fths_front, fths_accum.
`default_nettype none

// Streams one float32 element per cycle while in_ready is high, and emits one
// summary beat when the element marked last has been folded in. An element
// passes an input register, a classify/square stage and the accumulate stage,
// which registers the summary. The rate of one element per cycle
// is set by the accumulate stage, where the float64 sum and sum of squares
// each take one rounded add per element. in_ready drops only while a last
// element waits on a summary that has not yet been taken. Configuration writes
// are taken every cycle and must land between elements.
module float_tensor_health_statistics
    import fths_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] value_bits,
    input  wire logic        last_element,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      finite_total,
    output logic [31:0]      nan_total,
    output logic [31:0]      inf_total,
    output logic [31:0]      zero_total,
    output logic [31:0]      exploding_total,
    output logic [31:0]      saturated_total,
    output logic [31:0]      observed_total,
    output logic             saturation_valid,
    output logic [31:0]      min_bits,
    output logic [31:0]      max_bits,
    output logic [63:0]      sum_bits,
    output logic [63:0]      sum_squares_bits,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [2:0]             kind_reg;
    logic [30:0]            expl_thr_reg;
    logic [29:0]            soft_thr_reg;
    logic [CLASS_WIDTH-1:0] row_len_reg;

    logic     en;
    elem_t    elem;
    acc_cfg_t acc_cfg;
    result_t  result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_NONE;
            expl_thr_reg <= 31'h4974_2400;
            soft_thr_reg <= 30'h3F7F_BE77;
            row_len_reg <= CLASS_WIDTH'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PRODUCER_KIND:       kind_reg <= cfg_data[2:0];
                CFG_EXPLODING_THRESHOLD: expl_thr_reg <= cfg_data[30:0];
                CFG_SOFTMAX_THRESHOLD:   soft_thr_reg <= cfg_data[29:0];
                CFG_ROW_LENGTH:          row_len_reg <= cfg_data[CLASS_WIDTH-1:0];
            endcase
        end
    end

    assign in_ready = en;

    assign acc_cfg.kind = kind_reg;
    assign acc_cfg.softmax_threshold = soft_thr_reg;
    assign acc_cfg.row_length = row_len_reg;

    fths_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .en                  (en),
        .in_valid            (in_valid),
        .value_bits          (value_bits),
        .last_element        (last_element),
        .kind                (kind_reg),
        .exploding_threshold (expl_thr_reg),
        .elem                (elem)
    );

    fths_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem      (elem),
        .cfg       (acc_cfg),
        .en        (en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign finite_total = result.finite_total;
    assign nan_total = result.nan_total;
    assign inf_total = result.inf_total;
    assign zero_total = result.zero_total;
    assign exploding_total = result.exploding_total;
    assign saturated_total = result.saturated_total;
    assign observed_total = result.observed_total;
    assign saturation_valid = result.saturation_valid;
    assign min_bits = result.min_bits;
    assign max_bits = result.max_bits;
    assign sum_bits = result.sum_bits;
    assign sum_squares_bits = result.sum_squares_bits;

endmodule

`default_nettype wire
